@@ src/ship_pkg.sv @@
// Shared types, constants and helper functions of the signature-based RRIP replacement block.
// Used by ship_victim and ship_rrip_replacement. It depends on nothing else.
package ship_pkg;

    // Sizing. SETS, WAYS and COUNTER_ENTRIES must be powers of two.
    localparam int SETS            = 2048;
    localparam int WAYS            = 16;
    localparam int COUNTER_ENTRIES = 1024;
    localparam int RRPV_W          = 2;
    localparam int CTR_W           = 3;

    // The signature is ten bits wide. The address loses its line offset first.
    localparam int SIG_W      = 10;
    localparam int LINE_SHIFT = 6;

    localparam int SET_AW      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_AW      = $clog2(WAYS);
    localparam int CTR_AW      = $clog2(COUNTER_ENTRIES);
    localparam int RRPV_LEVELS = 1 << RRPV_W;

    localparam logic [RRPV_W-1:0] RRPV_MAX = '1;
    localparam logic [CTR_W-1:0]  CTR_MAX  = '1;
    localparam logic [CTR_W-1:0]  CTR_INIT = CTR_MAX / 2;

    // The clearing pass covers both memories in one sweep.
    localparam int CLR_LEN = (SETS > COUNTER_ENTRIES) ? SETS : COUNTER_ENTRIES;
    localparam int CLR_W   = $clog2(CLR_LEN);

    // Stream widths: the input tdata is padded to whole bytes.
    localparam int IN_FIELDS_W = 11 + 4 + 10 + 16;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    // Per-way state of one cache line.
    typedef struct packed {
        logic [RRPV_W-1:0] rrpv;
        logic              valid;
        logic              reuse;
        logic [SIG_W-1:0]  sig;
    } t_line;

    typedef t_line [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // Outcome of the victim search on one set.
    typedef struct packed {
        logic [WAY_AW-1:0] way;
        t_row              row;
    } t_victim;

    // Contents of a set row after reset.
    function automatic t_row reset_row();
        t_row r;
        for (int w = 0; w < WAYS; w++) begin
            r[w].rrpv  = RRPV_MAX;
            r[w].valid = 1'b0;
            r[w].reuse = 1'b0;
            r[w].sig   = '0;
        end
        return r;
    endfunction

    // Counter table slot of a signature: the low bits of the signature.
    function automatic logic [CTR_AW-1:0] sig_slot(input logic [SIG_W-1:0] sig);
        logic [SIG_W+CTR_AW-1:0] wide;
        wide = {{CTR_AW{1'b0}}, sig};
        return wide[CTR_AW-1:0];
    endfunction

endpackage

@@ src/ship_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stands alone; it uses no package.
module ship_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port: the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/ship_victim.sv @@
// Victim search and ageing over one set row read from the set memory.
// Depends on ship_pkg for the line and row types.
module ship_victim (
    input  ship_pkg::t_row    i_row,
    output ship_pkg::t_victim o_victim
);

    logic                               any_inv;
    logic [ship_pkg::WAY_AW-1:0]        inv_way;
    logic [ship_pkg::RRPV_LEVELS-1:0]   present;
    logic [ship_pkg::RRPV_W-1:0]        max_val;
    logic [ship_pkg::RRPV_W-1:0]        delta;
    logic [ship_pkg::WAY_AW-1:0]        max_way;
    ship_pkg::t_row                     aged;

    // Ageing until one way reaches the maximum is the same as adding the
    // distance between the largest value in the set and the maximum.
    always_comb begin
        any_inv = 1'b0;
        inv_way = '0;
        for (int w = ship_pkg::WAYS - 1; w >= 0; w--) begin
            if (!i_row[w].valid) begin
                any_inv = 1'b1;
                inv_way = ship_pkg::WAY_AW'(w);
            end
        end

        present = '0;
        for (int w = 0; w < ship_pkg::WAYS; w++) begin
            present[i_row[w].rrpv] = 1'b1;
        end

        max_val = '0;
        for (int v = 0; v < ship_pkg::RRPV_LEVELS; v++) begin
            if (present[v]) begin
                max_val = ship_pkg::RRPV_W'(v);
            end
        end
        delta = ship_pkg::RRPV_MAX - max_val;

        max_way = '0;
        for (int w = ship_pkg::WAYS - 1; w >= 0; w--) begin
            if (i_row[w].rrpv == max_val) begin
                max_way = ship_pkg::WAY_AW'(w);
            end
        end

        aged = i_row;
        if (!any_inv) begin
            for (int w = 0; w < ship_pkg::WAYS; w++) begin
                aged[w].rrpv = i_row[w].rrpv + delta;
            end
        end

        o_victim.way = any_inv ? inv_way : max_way;
        o_victim.row = aged;
    end

endmodule

@@ src/ship_rrip_replacement.sv @@
// Top level of the signature-based RRIP replacement block.
// Depends on ship_pkg, ship_ram (set and counter memories) and ship_victim.
//
// Usage
// - Slave stream: one item per cache access. tdata carries the set, the hit way,
//   the low program counter bits and the low address bits; tuser is the hit flag.
// - Master stream: one item per access with the way used, whether a valid line
//   was evicted and whether the new line went in at the distant value.
// - The state of all sets lives in one set memory (one row of all ways per set)
//   and the signature counters in a second memory, both with a registered read
//   port. Each access reads its set row, modifies it and writes it back.
// - A hit takes the row read, then writes the row back and loads the result.
//   A miss takes row read, victim search with ageing, counter training, then
//   insertion. A new item is accepted only after the current one is done.
//   The set row read-modify-write and the two dependent counter accesses set
//   this sequence.
// - After reset a clearing pass writes every set row and every counter entry
//   in one sweep; no item is accepted meanwhile.
// - One result register sits on the master side. While it is held by a stalled
//   receiver the next item is still accepted and worked on, and waits only at
//   its final write-back until the register is free.
module ship_rrip_replacement (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: set_index[10:0], hit_way[14:11], pc_low[24:15], addr_low[40:25], zeros.
    input  logic [ship_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: is_hit.
    input  logic                              s_axis_tuser,
    // Master stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: way_used[3:0], evicted_valid[4], inserted_distant[5], zeros.
    output logic [ship_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ROW   = 5'b00100,
        S_TRAIN = 5'b01000,
        S_INS   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [ship_pkg::CLR_W-1:0]  r_clr;

    // Access held for the duration of its work.
    logic [ship_pkg::SET_AW-1:0] r_set;
    logic                        r_hit;
    logic [ship_pkg::WAY_AW-1:0] r_hway;
    logic [ship_pkg::SIG_W-1:0]  r_sig;

    // Miss path registers.
    ship_pkg::t_row              r_row;
    logic [ship_pkg::WAY_AW-1:0] r_way;
    logic [ship_pkg::CTR_W-1:0]  r_trained;
    logic                        r_fwd;

    // Result register.
    logic                        r_out_valid;
    logic [ship_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [ship_pkg::OUT_TDATA_W-1:0] n_out_data;
    logic                        out_free;
    logic                        out_load;

    // Memory ports.
    logic                        set_wr_en;
    logic [ship_pkg::SET_AW-1:0] set_wr_addr;
    ship_pkg::t_row              set_wr_data;
    logic                        set_rd_en;
    logic [ship_pkg::SET_AW-1:0] set_rd_addr;
    ship_pkg::t_row              set_rd_data;

    logic                        ctr_wr_en;
    logic [ship_pkg::CTR_AW-1:0] ctr_wr_addr;
    logic [ship_pkg::CTR_W-1:0]  ctr_wr_data;
    logic                        ctr_rd_en;
    logic [ship_pkg::CTR_AW-1:0] ctr_rd_addr;
    logic [ship_pkg::CTR_W-1:0]  ctr_rd_data;

    ship_pkg::t_victim           victim;

    // Input field decode.
    logic [ship_pkg::SET_AW+10:0]  set_wide;
    logic [ship_pkg::WAY_AW+3:0]   hway_wide;
    logic [9:0]                    in_pc;
    logic [15:0]                   in_addr;
    logic [ship_pkg::SIG_W-1:0]    in_sig;

    // Working values.
    ship_pkg::t_row              hit_row;
    ship_pkg::t_row              ins_row;
    ship_pkg::t_line             old_line;
    logic [ship_pkg::CTR_AW-1:0] old_slot;
    logic [ship_pkg::CTR_AW-1:0] new_slot;
    logic [ship_pkg::CTR_W-1:0]  trained;
    logic [ship_pkg::CTR_W-1:0]  new_ctr;
    logic                        distant;
    logic [ship_pkg::WAY_AW+3:0] way_wide;
    logic                        accept;
    logic                        clr_last;

    // Memories and victim search.
    ship_ram #(
        .WIDTH (ship_pkg::ROW_W),
        .DEPTH (ship_pkg::SETS)
    ) u_set_ram (
        .i_clk     (i_clk),
        .i_wr_en   (set_wr_en),
        .i_wr_addr (set_wr_addr),
        .i_wr_data (set_wr_data),
        .i_rd_en   (set_rd_en),
        .i_rd_addr (set_rd_addr),
        .o_rd_data (set_rd_data)
    );

    ship_ram #(
        .WIDTH (ship_pkg::CTR_W),
        .DEPTH (ship_pkg::COUNTER_ENTRIES)
    ) u_ctr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ctr_wr_en),
        .i_wr_addr (ctr_wr_addr),
        .i_wr_data (ctr_wr_data),
        .i_rd_en   (ctr_rd_en),
        .i_rd_addr (ctr_rd_addr),
        .o_rd_data (ctr_rd_data)
    );

    ship_victim u_victim (
        .i_row    (set_rd_data),
        .o_victim (victim)
    );

    // Handshakes.
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign clr_last      = (r_clr == ship_pkg::CLR_W'(ship_pkg::CLR_LEN - 1));

    // Field extraction; the set and the way wrap at the table sizes.
    assign set_wide  = {{ship_pkg::SET_AW{1'b0}}, s_axis_tdata[10:0]};
    assign hway_wide = {{ship_pkg::WAY_AW{1'b0}}, s_axis_tdata[14:11]};
    assign in_pc     = s_axis_tdata[24:15];
    assign in_addr   = s_axis_tdata[40:25];
    assign in_sig    = in_pc ^ in_addr[ship_pkg::LINE_SHIFT +: ship_pkg::SIG_W];

    // Per-state datapath and memory control.
    always_comb begin
        n_state     = r_state;
        set_wr_en   = 1'b0;
        set_wr_addr = r_set;
        set_wr_data = r_row;
        set_rd_en   = 1'b0;
        set_rd_addr = set_wide[ship_pkg::SET_AW-1:0];
        ctr_wr_en   = 1'b0;
        ctr_wr_addr = '0;
        ctr_wr_data = r_trained;
        ctr_rd_en   = 1'b0;
        ctr_rd_addr = '0;
        out_load    = 1'b0;
        n_out_data  = '0;

        hit_row = set_rd_data;
        hit_row[r_hway].reuse = 1'b1;
        hit_row[r_hway].rrpv  = '0;

        old_line = r_row[r_way];
        old_slot = ship_pkg::sig_slot(old_line.sig);
        new_slot = ship_pkg::sig_slot(r_sig);
        trained  = ctr_rd_data;
        if (old_line.reuse) begin
            if (ctr_rd_data != ship_pkg::CTR_MAX) begin
                trained = ctr_rd_data + 1'b1;
            end
        end else if (ctr_rd_data != '0) begin
            trained = ctr_rd_data - 1'b1;
        end

        new_ctr = r_fwd ? r_trained : ctr_rd_data;
        distant = (new_ctr == '0);
        ins_row = r_row;
        ins_row[r_way].rrpv  = distant ? ship_pkg::RRPV_MAX : '0;
        ins_row[r_way].valid = 1'b1;
        ins_row[r_way].reuse = 1'b0;
        ins_row[r_way].sig   = r_sig;

        way_wide = '0;

        unique case (r_state)
            S_CLEAR: begin
                set_wr_en   = (32'(r_clr) < 32'(ship_pkg::SETS));
                set_wr_addr = r_clr[ship_pkg::SET_AW-1:0];
                set_wr_data = ship_pkg::reset_row();
                ctr_wr_en   = (32'(r_clr) < 32'(ship_pkg::COUNTER_ENTRIES));
                ctr_wr_addr = r_clr[ship_pkg::CTR_AW-1:0];
                ctr_wr_data = ship_pkg::CTR_INIT;
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                set_rd_en = accept;
                if (accept) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (r_hit) begin
                    // Hit: mark reuse, bring the line to near and report it.
                    way_wide = {4'b0000, r_hway};
                    if (out_free) begin
                        set_wr_en   = 1'b1;
                        set_wr_data = hit_row;
                        out_load    = 1'b1;
                        n_out_data  = ship_pkg::OUT_TDATA_W'(way_wide[3:0]);
                        n_state     = S_IDLE;
                    end
                end else begin
                    // Miss: look up the counter of the line about to leave.
                    ctr_rd_en   = 1'b1;
                    ctr_rd_addr = ship_pkg::sig_slot(victim.row[victim.way].sig);
                    n_state     = S_TRAIN;
                end
            end
            S_TRAIN: begin
                // Train the old signature and fetch the new one.
                ctr_wr_en   = old_line.valid;
                ctr_wr_addr = old_slot;
                ctr_wr_data = trained;
                ctr_rd_en   = 1'b1;
                ctr_rd_addr = new_slot;
                n_state     = S_INS;
            end
            S_INS: begin
                // Install the new line and report the fill.
                way_wide = {4'b0000, r_way};
                if (out_free) begin
                    set_wr_en   = 1'b1;
                    set_wr_data = ins_row;
                    out_load    = 1'b1;
                    n_out_data  = ship_pkg::OUT_TDATA_W'({distant, old_line.valid,
                                                         way_wide[3:0]});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set  <= set_wide[ship_pkg::SET_AW-1:0];
            r_hit  <= s_axis_tuser;
            r_hway <= hway_wide[ship_pkg::WAY_AW-1:0];
            r_sig  <= in_sig;
        end
        if (r_state == S_ROW && !r_hit) begin
            r_row <= victim.row;
            r_way <= victim.way;
        end
        if (r_state == S_TRAIN) begin
            r_trained <= trained;
            r_fwd     <= old_line.valid && (old_slot == new_slot);
        end
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

    // Checks on the sequencing.
    a_accept_reads_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_ROW))
        else $error("accepted item did not move on to the row read");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten while held");

    a_ctr_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctr_wr_en |-> (r_state == S_TRAIN || r_state == S_CLEAR))
        else $error("counter write outside training or clearing");

    a_hit_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_state == S_ROW) |-> (n_out_data[5:4] == 2'b00))
        else $error("hit result carries eviction or insertion flags");

    a_miss_goes_training: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW && !r_hit) |=> (r_state == S_TRAIN))
        else $error("miss skipped the counter training step");

endmodule
